// ===== hdl/svramp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Servo ramp package
// Shared constants and types for the servo linear ramp step core.
// ----------------------------------------------------------------------------
package svramp_pkg;

	localparam int NUM_MOTORS_DEF = 8;
	localparam int POS_BITS_DEF   = 16;

	localparam int IDX_BITS   = 3;
	localparam int IN_POS_W   = 16;
	localparam int SPEED_W    = 12;
	localparam int PERIOD_W   = 16;
	localparam int PROD_W     = SPEED_W + PERIOD_W;
	localparam int CALC_W     = 34;

	typedef struct packed {
		logic wr_en;
		logic moving;
	} svramp_ctl_t;

endpackage : svramp_pkg
`default_nettype wire

// ===== hdl/servo_linear_ramp_step_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Servo linear ramp step core
// Steps a per-motor linear position ramp for a bank of servo channels.
// Each request passes the input register and then the result register; one request per cycle while out_stall is low.
// The speed by period product is taken at the input register, and the
// position update runs between that register and the result register.
// Reset clears all stored motor positions to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module servo_linear_ramp_step_core
	import svramp_pkg::*;
#(
	parameter int NUM_MOTORS = NUM_MOTORS_DEF,
	parameter int POS_BITS   = POS_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [IDX_BITS-1:0] motor_index,
	input  wire logic [IN_POS_W-1:0] start_pos,
	input  wire logic [IN_POS_W-1:0] end_pos,
	input  wire logic [SPEED_W-1:0]  speed,
	input  wire logic [PERIOD_W-1:0] period_count,
	input  wire logic                dead_time,
	input  wire logic                stop_request,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic                     moving,
	output logic [IN_POS_W-1:0]      position
);

	localparam int                IN_BITS = (POS_BITS < IN_POS_W) ? POS_BITS : IN_POS_W;
	localparam logic [IN_POS_W-1:0] IN_MASK = {IN_POS_W{1'b1}} >> (IN_POS_W - IN_BITS);

	logic                valid_s1;
	logic [IDX_BITS-1:0] idx_s1;
	logic [IN_POS_W-1:0] start_s1;
	logic [IN_POS_W-1:0] end_s1;
	logic [SPEED_W-1:0]  speed_s1;
	logic [PROD_W-1:0]   prod_s1;
	logic                window_s1;
	logic                stop_s1;

	logic                out_valid_q;
	logic                moving_q;
	logic [IN_POS_W-1:0] position_q;

	logic                out_ready;
	logic                s1_ready;
	logic                s1_fire;
	logic                in_fire;

	svramp_ctl_t         ctl;
	logic [POS_BITS-1:0] cur_pos;
	logic [POS_BITS-1:0] new_pos;
	logic [POS_BITS-1:0] after_pos;
	logic                idx_ok;

	assign out_ready = !out_valid_q || !out_stall;
	assign s1_ready  = !valid_s1 || out_ready;
	assign in_stall  = !s1_ready;
	assign in_fire   = in_valid && s1_ready;
	assign s1_fire   = valid_s1 && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			idx_s1    <= motor_index;
			start_s1  <= start_pos & IN_MASK;
			end_s1    <= end_pos & IN_MASK;
			speed_s1  <= speed;
			prod_s1   <= PROD_W'(speed) * PROD_W'(period_count);
			window_s1 <= dead_time;
			stop_s1   <= stop_request;
		end
	end

	svramp_pos_bank #(
		.NUM_MOTORS(NUM_MOTORS),
		.POS_BITS  (POS_BITS)
	) u_bank (
		.clk        (clk),
		.arst_n     (arst_n),
		.motor_index(idx_s1),
		.wr_en      (s1_fire && ctl.wr_en),
		.wr_pos     (new_pos),
		.idx_ok     (idx_ok),
		.rd_pos     (cur_pos)
	);

	svramp_calc #(
		.POS_BITS(POS_BITS)
	) u_calc (
		.start_pos   (start_s1),
		.end_pos     (end_s1),
		.speed       (speed_s1),
		.product     (prod_s1),
		.cur_pos     (cur_pos),
		.dead_time   (window_s1),
		.stop_request(stop_s1),
		.ctl         (ctl),
		.new_pos     (new_pos)
	);

	assign after_pos = ctl.wr_en ? new_pos : cur_pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			moving_q   <= idx_ok && ctl.moving;
			position_q <= idx_ok ? IN_POS_W'(after_pos) : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign moving    = moving_q;
	assign position  = position_q;

	a_bad_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && !idx_ok) |=> (!moving && position == '0))
		else $error("out-of-range motor did not give a zero result");

	a_closed_window_moving: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && idx_ok && !window_s1) |=> moving)
		else $error("closed dead window did not report moving");

	a_closed_window_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && idx_ok && !window_s1) |=> position == $past(IN_POS_W'(cur_pos)))
		else $error("closed dead window changed the position");

	a_result_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s1))
		else $error("result appeared without a request in the input register");

endmodule : servo_linear_ramp_step_core
`default_nettype wire

// ===== hdl/svramp_calc.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Servo ramp step calculation
// Computes the new ramp position of one motor and decides whether the move
// is finished, using exact signed integer arithmetic.
// ----------------------------------------------------------------------------
module svramp_calc
	import svramp_pkg::*;
#(
	parameter int POS_BITS = POS_BITS_DEF
) (
	input  wire logic [IN_POS_W-1:0] start_pos,
	input  wire logic [IN_POS_W-1:0] end_pos,
	input  wire logic [SPEED_W-1:0]  speed,
	input  wire logic [PROD_W-1:0]   product,
	input  wire logic [POS_BITS-1:0] cur_pos,
	input  wire logic                dead_time,
	input  wire logic                stop_request,
	output svramp_ctl_t              ctl,
	output logic [POS_BITS-1:0]      new_pos
);

	logic signed [CALC_W-1:0] s_x;
	logic signed [CALC_W-1:0] e_x;
	logic signed [CALC_W-1:0] p_x;
	logic signed [CALC_W-1:0] v_x;
	logic signed [CALC_W-1:0] c_x;
	logic signed [CALC_W-1:0] tgt;
	logic signed [CALC_W-1:0] nxt;
	logic                     ascend;
	logic                     over;
	logic                     hold;

	assign s_x = signed'(CALC_W'(start_pos));
	assign e_x = signed'(CALC_W'(end_pos));
	assign p_x = signed'(CALC_W'(product));
	assign v_x = signed'(CALC_W'(speed));
	assign c_x = signed'(CALC_W'(cur_pos));

	assign ascend = end_pos > start_pos;
	assign tgt    = ascend ? (s_x + p_x) : (s_x - p_x);
	assign nxt    = ascend ? (tgt + v_x) : (tgt - v_x);
	assign over   = ascend ? ((nxt <<< 1) > ((e_x <<< 1) + v_x))
	                       : ((nxt <<< 1) < ((e_x <<< 1) - v_x));
	assign hold   = stop_request || (ascend ? (c_x >= e_x) : (c_x < e_x));

	always_comb begin
		ctl.wr_en  = 1'b0;
		ctl.moving = 1'b1;
		new_pos    = over ? POS_BITS'(end_pos) : tgt[POS_BITS-1:0];
		if (dead_time) begin
			if (hold) begin
				ctl.moving = 1'b0;
			end else begin
				ctl.wr_en  = 1'b1;
				ctl.moving = !over;
			end
		end
	end

endmodule : svramp_calc
`default_nettype wire

// ===== hdl/svramp_pos_bank.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Servo position bank
// Holds the stored position of every motor, with one read and one write
// at the same motor address.
// ----------------------------------------------------------------------------
module svramp_pos_bank
	import svramp_pkg::*;
#(
	parameter int NUM_MOTORS = NUM_MOTORS_DEF,
	parameter int POS_BITS   = POS_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [IDX_BITS-1:0] motor_index,
	input  wire logic                wr_en,
	input  wire logic [POS_BITS-1:0] wr_pos,
	output logic                     idx_ok,
	output logic [POS_BITS-1:0]      rd_pos
);

	localparam int ADDR_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

	logic [POS_BITS-1:0] pos_q [NUM_MOTORS];
	logic [ADDR_W-1:0]   addr;

	assign idx_ok = 32'(motor_index) < NUM_MOTORS;
	assign addr   = ADDR_W'(motor_index);
	assign rd_pos = idx_ok ? pos_q[addr] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_MOTORS; i++) begin
				pos_q[i] <= '0;
			end
		end else if (wr_en && idx_ok) begin
			pos_q[addr] <= wr_pos;
		end
	end

endmodule : svramp_pos_bank
`default_nettype wire
